// ===== hdl/motion_grid_bounding_box_defines.svh =====
// Assertion helpers shared by the motion grid blocks.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef MOTION_GRID_BOUNDING_BOX_DEFINES_SVH
`define MOTION_GRID_BOUNDING_BOX_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define MGBB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define MGBB_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/mgbb_pkg.sv =====
`timescale 1ns / 1ps

package mgbb_pkg;

  // Grid store geometry
  localparam int unsigned MaxGridCells = 16384;
  localparam int unsigned MaxGridSide  = 128;
  localparam int unsigned AddrW        = $clog2(MaxGridCells);
  localparam int unsigned SideW        = $clog2(MaxGridSide);

  // Field widths
  localparam int unsigned LumaW    = 8;
  localparam int unsigned DimW     = 14;
  localparam int unsigned CellW    = 7;
  localparam int unsigned GridW    = 8;
  localparam int unsigned CountW   = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CountW-1:0] CountMax = '1;

  // Pixel positions before clamping: (side index + 1) * cell size
  localparam int unsigned PosW = SideW + 1 + CellW;

  // Margin of a fifth, done as multiply by a rounded-up reciprocal.
  // The extra two bits of shift keep the quotient exact for any PosW-bit span.
  localparam int unsigned MarginDiv   = 5;
  localparam int unsigned MarginShift = PosW + 2;
  localparam int unsigned MarginRecip = ((2 ** MarginShift) + MarginDiv - 1) / MarginDiv;
  localparam int unsigned ProdW       = PosW + MarginShift;

  // Register reset values
  localparam logic [DimW-1:0]     FrameWidthRst  = 14'd1920;
  localparam logic [DimW-1:0]     FrameHeightRst = 14'd1080;
  localparam logic [CellW-1:0]    CellSizeRst    = 7'd16;
  localparam logic [GridW-1:0]    GridWidthRst   = 8'd120;
  localparam logic [GridW-1:0]    GridHeightRst  = 8'd67;
  localparam logic [LumaW-1:0]    ThresholdRst   = 8'd25;
  localparam logic [CountW-1:0]   MinChangedRst  = 15'd4;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegCellSize    = 3'd2,
    RegGridWidth   = 3'd3,
    RegGridHeight  = 3'd4,
    RegThreshold   = 3'd5,
    RegMinChanged  = 3'd6
  } cfg_reg_e;

  // Effective configuration as seen by the datapath
  typedef struct packed {
    logic [DimW-1:0]   frame_width;
    logic [DimW-1:0]   frame_height;
    logic [CellW-1:0]  cell_size;
    logic [SideW-1:0]  gw_m1;
    logic [SideW-1:0]  gh_m1;
    logic [LumaW-1:0]  threshold;
    logic [CountW-1:0] min_changed;
  } cfg_t;

  // Per-frame change statistics
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SideW-1:0]  min_col;
    logic [SideW-1:0]  max_col;
    logic [SideW-1:0]  min_row;
    logic [SideW-1:0]  max_row;
  } stats_t;

  localparam stats_t StatsClear = '{
    count:   '0,
    min_col: '1,
    max_col: '0,
    min_row: '1,
    max_row: '0
  };

  typedef struct packed {
    logic [DimW-1:0] pos;
    logic [DimW-1:0] len;
  } edge_t;

  // Last valid index for a grid side register: zero reads as one, clamp to max.
  function automatic logic [SideW-1:0] side_last(logic [GridW-1:0] v);
    logic [SideW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (32'(v) > MaxGridSide) begin
      res = SideW'(MaxGridSide - 1);
    end else begin
      res = SideW'(v - GridW'(1));
    end
    return res;
  endfunction

endpackage

// ===== hdl/motion_grid_bounding_box.sv =====
`timescale 1ns / 1ps
// Frame-difference motion detector over a grid of downsampled luma cells.
// Input channel (in_valid_i/in_ready_o, cell_luma_i): one cell mean per
// transaction, in raster order over a grid_width by grid_height grid.
// Output channel (out_valid_o/out_ready_i): one transaction per frame, after
// its last cell: changed cell count, active flag and the motion rectangle in
// pixels, widened by a fifth per side and clamped to the frame.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): always
// ready; write only while no frame is in flight. Writing grid_width or
// grid_height restarts the scan and makes the next frame a first frame.
// Throughput: one cell per cycle while input ready is high (see Stall), set by
// the single read-modify-write port of the previous-frame RAM (read and write
// of a cell in the same cycle). The last cell of a frame moves on through the
// RAM read, stats capture, pixel scaling, margin and output register stages.
// Reset: registers return to their defaults and the first frame compares
// nothing (count 0, inactive); the RAM is not cleared.
// Stall: up to four results queue inside the region pipe; once full, input
// ready drops on the last cell of the following frame until one is taken.

module motion_grid_bounding_box (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mgbb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mgbb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mgbb_pkg::LumaW-1:0]    cell_luma_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          motion_active_o,
  output logic [mgbb_pkg::CountW-1:0]   changed_count_o,
  output logic [mgbb_pkg::DimW-1:0]     roi_x_o,
  output logic [mgbb_pkg::DimW-1:0]     roi_y_o,
  output logic [mgbb_pkg::DimW-1:0]     roi_w_o,
  output logic [mgbb_pkg::DimW-1:0]     roi_h_o
);

  mgbb_pkg::cfg_t   cfg;
  mgbb_pkg::stats_t stats;
  logic             grid_wr;
  logic             stats_valid;
  logic             stats_ready;

  mgbb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .grid_wr_o   (grid_wr)
  );

  mgbb_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .grid_wr_i     (grid_wr),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cell_luma_i   (cell_luma_i),
    .stats_valid_o (stats_valid),
    .stats_o       (stats),
    .stats_ready_i (stats_ready)
  );

  mgbb_roi u_roi (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .stats_valid_i   (stats_valid),
    .stats_i         (stats),
    .stats_ready_o   (stats_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .motion_active_o (motion_active_o),
    .changed_count_o (changed_count_o),
    .roi_x_o         (roi_x_o),
    .roi_y_o         (roi_y_o),
    .roi_w_o         (roi_w_o),
    .roi_h_o         (roi_h_o)
  );

endmodule

// ===== hdl/mgbb_ram.sv =====
`timescale 1ns / 1ps

module mgbb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read-first: a write and a read of the same entry return the old contents
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mgbb_cfg.sv =====
`timescale 1ns / 1ps

module mgbb_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mgbb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mgbb_pkg::CfgDataW-1:0]    cfg_data_i,
  output mgbb_pkg::cfg_t                   cfg_o,
  output logic                             grid_wr_o
);

  logic [mgbb_pkg::DimW-1:0]   frame_width_q, frame_width_d;
  logic [mgbb_pkg::DimW-1:0]   frame_height_q, frame_height_d;
  logic [mgbb_pkg::CellW-1:0]  cell_size_q, cell_size_d;
  logic [mgbb_pkg::GridW-1:0]  grid_width_q, grid_width_d;
  logic [mgbb_pkg::GridW-1:0]  grid_height_q, grid_height_d;
  logic [mgbb_pkg::LumaW-1:0]  threshold_q, threshold_d;
  logic [mgbb_pkg::CountW-1:0] min_changed_q, min_changed_d;
  logic                        cfg_fire;
  mgbb_pkg::cfg_reg_e          reg_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign reg_sel     = mgbb_pkg::cfg_reg_e'(cfg_index_i);

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    cell_size_d    = cell_size_q;
    grid_width_d   = grid_width_q;
    grid_height_d  = grid_height_q;
    threshold_d    = threshold_q;
    min_changed_d  = min_changed_q;
    if (cfg_fire) begin
      unique case (reg_sel)
        mgbb_pkg::RegFrameWidth:  frame_width_d  = cfg_data_i[mgbb_pkg::DimW-1:0];
        mgbb_pkg::RegFrameHeight: frame_height_d = cfg_data_i[mgbb_pkg::DimW-1:0];
        mgbb_pkg::RegCellSize:    cell_size_d    = cfg_data_i[mgbb_pkg::CellW-1:0];
        mgbb_pkg::RegGridWidth:   grid_width_d   = cfg_data_i[mgbb_pkg::GridW-1:0];
        mgbb_pkg::RegGridHeight:  grid_height_d  = cfg_data_i[mgbb_pkg::GridW-1:0];
        mgbb_pkg::RegThreshold:   threshold_d    = cfg_data_i[mgbb_pkg::LumaW-1:0];
        mgbb_pkg::RegMinChanged:  min_changed_d  = cfg_data_i[mgbb_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= mgbb_pkg::FrameWidthRst;
      frame_height_q <= mgbb_pkg::FrameHeightRst;
      cell_size_q    <= mgbb_pkg::CellSizeRst;
      grid_width_q   <= mgbb_pkg::GridWidthRst;
      grid_height_q  <= mgbb_pkg::GridHeightRst;
      threshold_q    <= mgbb_pkg::ThresholdRst;
      min_changed_q  <= mgbb_pkg::MinChangedRst;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      cell_size_q    <= cell_size_d;
      grid_width_q   <= grid_width_d;
      grid_height_q  <= grid_height_d;
      threshold_q    <= threshold_d;
      min_changed_q  <= min_changed_d;
    end
  end

  // A grid size write restarts the scan and drops the stored frame
  assign grid_wr_o = cfg_fire &&
                     (reg_sel == mgbb_pkg::RegGridWidth || reg_sel == mgbb_pkg::RegGridHeight);

  assign cfg_o.frame_width  = frame_width_q;
  assign cfg_o.frame_height = frame_height_q;
  assign cfg_o.cell_size    = (cell_size_q == '0) ? mgbb_pkg::CellW'(1) : cell_size_q;
  assign cfg_o.gw_m1        = mgbb_pkg::side_last(grid_width_q);
  assign cfg_o.gh_m1        = mgbb_pkg::side_last(grid_height_q);
  assign cfg_o.threshold    = threshold_q;
  assign cfg_o.min_changed  = min_changed_q;

endmodule

// ===== hdl/mgbb_scan.sv =====
`timescale 1ns / 1ps
`include "motion_grid_bounding_box_defines.svh"

module mgbb_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mgbb_pkg::cfg_t                cfg_i,
  input  logic                          grid_wr_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mgbb_pkg::LumaW-1:0]    cell_luma_i,
  output logic                          stats_valid_o,
  output mgbb_pkg::stats_t              stats_o,
  input  logic                          stats_ready_i
);

  // Raster position of the next cell
  logic [mgbb_pkg::SideW-1:0] col_q, col_d;
  logic [mgbb_pkg::SideW-1:0] row_q, row_d;
  logic [mgbb_pkg::AddrW-1:0] addr_q, addr_d;
  logic                       pv_q, pv_d;

  // Compare stage: cell waiting for its stored value
  logic                       s1_v_q, s1_v_d;
  logic [mgbb_pkg::SideW-1:0] s1_col_q, s1_row_q;
  logic [mgbb_pkg::LumaW-1:0] s1_luma_q;
  logic                       s1_pv_q, s1_last_q;

  mgbb_pkg::stats_t           acc_q, acc_d, upd;
  logic [mgbb_pkg::LumaW-1:0] prev_luma;
  logic [mgbb_pkg::LumaW-1:0] diff;
  logic                       changed;
  logic                       in_fire, s1_fire, s1_hold;
  logic                       col_end, row_end, is_last;

  assign col_end = (col_q == cfg_i.gw_m1);
  assign row_end = (row_q == cfg_i.gh_m1);
  assign is_last = col_end && row_end;

  // Hold the last cell of a frame until the region pipe takes its stats
  assign s1_hold    = s1_v_q && s1_last_q && !stats_ready_i;
  assign in_ready_o = !s1_hold;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_fire    = s1_v_q && !s1_hold;

  mgbb_ram #(
    .Width (mgbb_pkg::LumaW),
    .Depth (mgbb_pkg::MaxGridCells)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .en_i    (in_fire),
    .we_i    (1'b1),
    .addr_i  (addr_q),
    .wdata_i (cell_luma_i),
    .rdata_o (prev_luma)
  );

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    addr_d = addr_q;
    pv_d   = pv_q;
    priority if (grid_wr_i) begin
      col_d  = '0;
      row_d  = '0;
      addr_d = '0;
      pv_d   = 1'b0;
    end else if (in_fire) begin
      if (col_end) begin
        col_d = '0;
        if (row_end) begin
          row_d = '0;
          pv_d  = 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
      if (is_last || addr_q == mgbb_pkg::AddrW'(mgbb_pkg::MaxGridCells - 1)) begin
        addr_d = '0;
      end else begin
        addr_d = addr_q + 1'b1;
      end
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_fire) begin
      s1_v_d = 1'b1;
    end else if (s1_fire) begin
      s1_v_d = 1'b0;
    end
  end

  always_comb begin
    diff    = (s1_luma_q > prev_luma) ? (s1_luma_q - prev_luma) : (prev_luma - s1_luma_q);
    changed = s1_pv_q && (diff > cfg_i.threshold);
    upd     = acc_q;
    if (changed) begin
      if (acc_q.count != mgbb_pkg::CountMax) begin
        upd.count = acc_q.count + 1'b1;
      end
      if (s1_col_q < acc_q.min_col) upd.min_col = s1_col_q;
      if (s1_col_q > acc_q.max_col) upd.max_col = s1_col_q;
      if (s1_row_q < acc_q.min_row) upd.min_row = s1_row_q;
      if (s1_row_q > acc_q.max_row) upd.max_row = s1_row_q;
    end
  end

  always_comb begin
    acc_d = acc_q;
    priority if (grid_wr_i) begin
      acc_d = mgbb_pkg::StatsClear;
    end else if (s1_fire) begin
      acc_d = s1_last_q ? mgbb_pkg::StatsClear : upd;
    end
  end

  assign stats_valid_o = s1_v_q && s1_last_q;
  assign stats_o       = upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      addr_q <= '0;
      pv_q   <= 1'b0;
      s1_v_q <= 1'b0;
      acc_q  <= mgbb_pkg::StatsClear;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      addr_q <= addr_d;
      pv_q   <= pv_d;
      s1_v_q <= s1_v_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_luma_q <= cell_luma_i;
      s1_pv_q   <= pv_q;
      s1_last_q <= is_last;
    end
  end

  `MGBB_ASSERT(a_frame_wrap, in_fire && is_last && !grid_wr_i |=> col_q == '0 && row_q == '0 && addr_q == '0 && pv_q, "raster did not wrap after last cell")
  `MGBB_ASSERT(a_box_order, acc_q.count != '0 |-> acc_q.min_col <= acc_q.max_col && acc_q.min_row <= acc_q.max_row, "bounding box inverted with nonzero count")
  `MGBB_ASSERT(a_hold_keeps_last, s1_hold |=> s1_v_q && s1_last_q, "held frame end lost from compare stage")

endmodule

// ===== hdl/mgbb_roi.sv =====
`timescale 1ns / 1ps
`include "motion_grid_bounding_box_defines.svh"

module mgbb_roi (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mgbb_pkg::cfg_t                cfg_i,
  input  logic                          stats_valid_i,
  input  mgbb_pkg::stats_t              stats_i,
  output logic                          stats_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          motion_active_o,
  output logic [mgbb_pkg::CountW-1:0]   changed_count_o,
  output logic [mgbb_pkg::DimW-1:0]     roi_x_o,
  output logic [mgbb_pkg::DimW-1:0]     roi_y_o,
  output logic [mgbb_pkg::DimW-1:0]     roi_w_o,
  output logic [mgbb_pkg::DimW-1:0]     roi_h_o
);

  // Widen by the margin, clamp both edges to the frame, floor the size at zero
  function automatic mgbb_pkg::edge_t edge_fit(logic [mgbb_pkg::PosW-1:0] lo_px,
                                               logic [mgbb_pkg::PosW-1:0] hi_px,
                                               logic [mgbb_pkg::PosW-1:0] margin,
                                               logic [mgbb_pkg::DimW-1:0] limit);
    logic [mgbb_pkg::PosW:0] lo;
    logic [mgbb_pkg::PosW:0] hi;
    logic [mgbb_pkg::PosW:0] lim;
    mgbb_pkg::edge_t         res;
    lim = (mgbb_pkg::PosW + 1)'(limit);
    lo  = (lo_px > margin) ? {1'b0, lo_px - margin} : '0;
    hi  = {1'b0, hi_px} + {1'b0, margin};
    if (hi > lim) hi = lim;
    if (lo > lim) lo = lim;
    res.pos = mgbb_pkg::DimW'(lo);
    res.len = (hi > lo) ? mgbb_pkg::DimW'(hi - lo) : '0;
    return res;
  endfunction

  // Stage A: captured stats
  logic             a_v_q, a_v_d;
  mgbb_pkg::stats_t a_q;

  // Stage B: cell edges scaled to pixels
  logic                        b_v_q, b_v_d;
  logic                        b_act_q;
  logic [mgbb_pkg::CountW-1:0] b_cnt_q;
  logic [mgbb_pkg::PosW-1:0]   b_ax_q, b_bx_q, b_ay_q, b_by_q;

  // Stage C: margins
  logic                        c_v_q, c_v_d;
  logic                        c_act_q;
  logic [mgbb_pkg::CountW-1:0] c_cnt_q;
  logic [mgbb_pkg::PosW-1:0]   c_ax_q, c_bx_q, c_mx_q, c_ay_q, c_by_q, c_my_q;

  // Output register
  logic                        out_v_q, out_v_d;
  logic                        act_q;
  logic [mgbb_pkg::CountW-1:0] cnt_q;
  logic [mgbb_pkg::DimW-1:0]   x_q, y_q, w_q, h_q;

  logic                        a_load, b_load, c_load, out_load;
  logic                        a_hold, b_hold, c_hold, out_free;
  logic                        act_a;
  logic [mgbb_pkg::PosW-1:0]   cs_ext;
  logic [mgbb_pkg::PosW-1:0]   dx, dy;
  logic [mgbb_pkg::ProdW-1:0]  prod_x, prod_y;
  mgbb_pkg::edge_t             fit_x, fit_y;

  assign out_free = !out_v_q || out_ready_i;
  assign c_hold   = c_v_q && !out_free;
  assign b_hold   = b_v_q && c_hold;
  assign a_hold   = a_v_q && b_hold;

  assign stats_ready_o = !a_hold;
  assign a_load        = stats_valid_i && stats_ready_o;
  assign b_load        = a_v_q && !b_hold;
  assign c_load        = b_v_q && !c_hold;
  assign out_load      = c_v_q && out_free;

  assign a_v_d   = a_load || a_hold;
  assign b_v_d   = b_load || b_hold;
  assign c_v_d   = c_load || c_hold;
  assign out_v_d = out_load || (out_v_q && !out_ready_i);

  assign act_a  = (a_q.count != '0) && (a_q.count >= cfg_i.min_changed);
  assign cs_ext = mgbb_pkg::PosW'(cfg_i.cell_size);

  assign dx     = b_bx_q - b_ax_q;
  assign dy     = b_by_q - b_ay_q;
  assign prod_x = mgbb_pkg::ProdW'(dx) * mgbb_pkg::ProdW'(mgbb_pkg::MarginRecip);
  assign prod_y = mgbb_pkg::ProdW'(dy) * mgbb_pkg::ProdW'(mgbb_pkg::MarginRecip);

  assign fit_x = edge_fit(c_ax_q, c_bx_q, c_mx_q, cfg_i.frame_width);
  assign fit_y = edge_fit(c_ay_q, c_by_q, c_my_q, cfg_i.frame_height);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      a_v_q   <= a_v_d;
      b_v_q   <= b_v_d;
      c_v_q   <= c_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_q <= stats_i;
    end
    if (b_load) begin
      b_act_q <= act_a;
      b_cnt_q <= a_q.count;
      b_ax_q  <= mgbb_pkg::PosW'(a_q.min_col) * cs_ext;
      b_bx_q  <= (mgbb_pkg::PosW'(a_q.max_col) + 1'b1) * cs_ext;
      b_ay_q  <= mgbb_pkg::PosW'(a_q.min_row) * cs_ext;
      b_by_q  <= (mgbb_pkg::PosW'(a_q.max_row) + 1'b1) * cs_ext;
    end
    if (c_load) begin
      c_act_q <= b_act_q;
      c_cnt_q <= b_cnt_q;
      c_ax_q  <= b_ax_q;
      c_bx_q  <= b_bx_q;
      c_ay_q  <= b_ay_q;
      c_by_q  <= b_by_q;
      c_mx_q  <= prod_x[mgbb_pkg::MarginShift +: mgbb_pkg::PosW];
      c_my_q  <= prod_y[mgbb_pkg::MarginShift +: mgbb_pkg::PosW];
    end
    if (out_load) begin
      act_q <= c_act_q;
      cnt_q <= c_cnt_q;
      x_q   <= c_act_q ? fit_x.pos : '0;
      y_q   <= c_act_q ? fit_y.pos : '0;
      w_q   <= c_act_q ? fit_x.len : '0;
      h_q   <= c_act_q ? fit_y.len : '0;
    end
  end

  assign out_valid_o     = out_v_q;
  assign motion_active_o = act_q;
  assign changed_count_o = cnt_q;
  assign roi_x_o         = x_q;
  assign roi_y_o         = y_q;
  assign roi_w_o         = w_q;
  assign roi_h_o         = h_q;

  `MGBB_ASSERT(a_idle_region_zero, out_v_q && !act_q |-> x_q == '0 && y_q == '0 && w_q == '0 && h_q == '0, "inactive result carries a region")
  `MGBB_ASSERT(a_backpressure_full, !stats_ready_o |-> a_v_q && b_v_q && c_v_q && out_v_q, "stats refused with a free stage")
  `MGBB_ASSERT_NEVER(a_active_zero_count, out_v_q && act_q && cnt_q == '0, "active result with zero count")

endmodule
